/* design/assert_macros.svh */
// Assertion macros shared by the verification checkers.
// No dependencies; included by name in the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* design/bf3_pkg.sv */
// Shared types and constants for the 3x3 RGB box filter.
// No dependencies.
`timescale 1ns / 1ps

package bf3_pkg;

    localparam int CFG_WIDTH_BITS  = 11;
    localparam int ROW_BITS        = 16;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int MIN_DIM         = 3;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    // Per-transaction tag carried down the pipeline.
    typedef struct packed {
        logic emit;
        logic last;
    } item_tag_t;

endpackage

/* design/bf3_cfg_regs.sv */
// APB register block: frame width and height, with clamped working copies.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_cfg_regs #(
    parameter int MAX_LINE = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bf3_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bf3_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bf3_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output logic [$clog2(MAX_LINE):0]           eff_width,
    output logic [bf3_pkg::ROW_BITS-1:0]        eff_height
);
    import bf3_pkg::*;

    localparam int CNT_W        = $clog2(MAX_LINE) + 1;
    localparam int WIDTH_RST_EF = (WIDTH_RESET > MAX_LINE) ? MAX_LINE : WIDTH_RESET;

    logic [CFG_WIDTH_BITS-1:0] width_reg, wr_width;
    logic [ROW_BITS-1:0]       height_reg, wr_height, height_clamped;
    logic [CNT_W-1:0]          eff_width_reg, width_clamped;
    logic [ROW_BITS-1:0]       eff_height_reg;
    logic                      wr_en;
    cfg_reg_t                  reg_sel;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_sel   = cfg_reg_t'(paddr[2]);
    assign wr_width  = pwdata[CFG_WIDTH_BITS-1:0];
    assign wr_height = pwdata[ROW_BITS-1:0];

    always_comb begin
        if (wr_width < CFG_WIDTH_BITS'(MIN_DIM)) begin
            width_clamped = CNT_W'(MIN_DIM);
        end else if (32'(wr_width) > MAX_LINE) begin
            width_clamped = CNT_W'(MAX_LINE);
        end else begin
            width_clamped = CNT_W'(wr_width);
        end
        height_clamped = (wr_height < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : wr_height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= CFG_WIDTH_BITS'(WIDTH_RESET);
            height_reg     <= ROW_BITS'(HEIGHT_RESET);
            eff_width_reg  <= CNT_W'(WIDTH_RST_EF);
            eff_height_reg <= ROW_BITS'(HEIGHT_RESET);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_WIDTH: begin
                    width_reg     <= wr_width;
                    eff_width_reg <= width_clamped;
                end
                REG_HEIGHT: begin
                    height_reg     <= wr_height;
                    eff_height_reg <= height_clamped;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
        endcase
    end

    assign eff_width  = eff_width_reg;
    assign eff_height = eff_height_reg;

endmodule

/* design/bf3_pos_track.sv */
// Raster position tracking: column/row counters, window-valid and end-of-frame tags.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_pos_track #(
    parameter int MAX_LINE = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic                               frame_start,
    input  logic [$clog2(MAX_LINE):0]          eff_width,
    input  logic [bf3_pkg::ROW_BITS-1:0]       eff_height,
    output logic [$clog2(MAX_LINE)-1:0]        col_addr,
    output bf3_pkg::item_tag_t                 tag
);
    import bf3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int CNT_W  = ADDR_W + 1;

    logic [ADDR_W-1:0]   col_reg, col_next, col_start, col_cur;
    logic [ROW_BITS-1:0] row_reg, row_next, row_start, row_step, row_cur;
    logic [CNT_W-1:0]    col_inc;
    logic [ROW_BITS:0]   row_inc;
    logic                last_col, last_row;

    always_comb begin
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;
        if ({1'b0, col_start} >= eff_width) begin
            col_cur  = '0;
            row_step = row_start + ROW_BITS'(1);
        end else begin
            col_cur  = col_start;
            row_step = row_start;
        end
        row_cur  = (row_step >= eff_height) ? '0 : row_step;
        col_inc  = {1'b0, col_cur} + CNT_W'(1);
        row_inc  = {1'b0, row_cur} + (ROW_BITS + 1)'(1);
        last_col = (col_inc >= eff_width);
        last_row = (row_inc >= {1'b0, eff_height});
        col_next = last_col ? '0 : col_inc[ADDR_W-1:0];
        if (last_col) begin
            row_next = last_row ? '0 : row_inc[ROW_BITS-1:0];
        end else begin
            row_next = row_cur;
        end
        tag.emit = (row_cur >= ROW_BITS'(2)) && (col_cur >= ADDR_W'(2));
        tag.last = (row_inc == {1'b0, eff_height}) && (col_inc == eff_width);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col_addr = col_cur;

endmodule

/* design/bf3_line_buf.sv */
// Two line-store memories (registered read) with write-back and same-entry forwarding.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_line_buf #(
    parameter int MAX_LINE    = 1024,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_LINE)-1:0]   rd_addr,
    input  logic [3*SAMPLE_BITS-1:0]      pix_in,
    input  logic                          wr_en,
    output logic [3*SAMPLE_BITS-1:0]      col_upper,
    output logic [3*SAMPLE_BITS-1:0]      col_middle,
    output logic [3*SAMPLE_BITS-1:0]      col_lower
);
    import bf3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int PIX_W  = 3 * SAMPLE_BITS;

    logic [PIX_W-1:0]  upper_mem  [MAX_LINE];
    logic [PIX_W-1:0]  middle_mem [MAX_LINE];
    logic [PIX_W-1:0]  upper_q_reg, middle_q_reg, pix_reg;
    logic [PIX_W-1:0]  fwd_upper_reg, fwd_middle_reg;
    logic [PIX_W-1:0]  upper_cur, middle_cur;
    logic [ADDR_W-1:0] addr_reg;
    logic              fwd_reg, fwd_next;

    assign fwd_next   = wr_en && (rd_addr == addr_reg);
    assign upper_cur  = fwd_reg ? fwd_upper_reg  : upper_q_reg;
    assign middle_cur = fwd_reg ? fwd_middle_reg : middle_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[addr_reg] <= middle_cur;
        end
        if (rd_en) begin
            upper_q_reg <= upper_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            middle_mem[addr_reg] <= pix_reg;
        end
        if (rd_en) begin
            middle_q_reg <= middle_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_reg       <= rd_addr;
            pix_reg        <= pix_in;
            fwd_upper_reg  <= middle_cur;
            fwd_middle_reg <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= fwd_next;
        end
    end

    assign col_upper  = upper_cur;
    assign col_middle = middle_cur;
    assign col_lower  = pix_reg;

endmodule

/* design/bf3_window_mean.sv */
// Window column sums, nine-sample totals and divide-by-9 output register.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_window_mean #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [3*SAMPLE_BITS-1:0]      col_upper,
    input  logic [3*SAMPLE_BITS-1:0]      col_middle,
    input  logic [3*SAMPLE_BITS-1:0]      col_lower,
    input  logic                          shift_en,
    input  logic                          sum_en,
    input  logic                          out_en,
    output logic [3*SAMPLE_BITS-1:0]      mean
);
    import bf3_pkg::*;

    localparam int COL_W     = SAMPLE_BITS + 2;
    localparam int SUM_W     = SAMPLE_BITS + 4;
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = DIV_SHIFT - 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

    logic [2:0][COL_W-1:0]       colsum, prev1_reg, prev2_reg;
    logic [2:0][SUM_W-1:0]       total, total_reg;
    logic [2:0][PROD_W-1:0]      prod;
    logic [2:0][SAMPLE_BITS-1:0] mean_next, mean_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            colsum[ch] = COL_W'(col_upper[ch*SAMPLE_BITS +: SAMPLE_BITS])
                       + COL_W'(col_middle[ch*SAMPLE_BITS +: SAMPLE_BITS])
                       + COL_W'(col_lower[ch*SAMPLE_BITS +: SAMPLE_BITS]);
            total[ch]  = SUM_W'(colsum[ch]) + SUM_W'(prev1_reg[ch]) + SUM_W'(prev2_reg[ch]);
            prod[ch]   = PROD_W'(total_reg[ch]) * PROD_W'(RECIP);
            mean_next[ch] = prod[ch][DIV_SHIFT +: SAMPLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev1_reg <= '0;
            prev2_reg <= '0;
        end else if (shift_en) begin
            prev1_reg <= colsum;
            prev2_reg <= prev1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            total_reg <= total;
        end
        if (out_en) begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

/* design/box_filter_3x3_rgb_unit.sv */
// 3x3 RGB box filter: top level with stream handshake and pipeline control.
// Depends on bf3_pkg, bf3_cfg_regs, bf3_pos_track, bf3_line_buf, bf3_window_mean.
//
// Usage:
//   Pixels enter on the s_ stream in raster order, red/green/blue in s_tdata and
//   the frame-start flag in s_tuser. For every interior pixel (not on the first
//   or last row or column) one transaction leaves on the m_ stream with the
//   truncated nine-sample mean per channel; m_tlast marks the last interior
//   pixel of a frame. Border pixels produce no output transaction.
//   Frame size is set over APB: width at 0x0, height at 0x4.
//   Pipeline: the line-store read, the window sum and the divide by 9 are each
//   registered in turn after the transaction that completes a window.
//   Throughput: one pixel per cycle while s_tready is high, set by the single read
//   and write port of each line store.
//   Stall: when m_tready is low, up to two further results are held in the
//   pipeline; after that s_tready drops. Border pixels keep flowing meanwhile.
//   Reset: position returns to row 0 column 0, size to 640x480, the column
//   window is cleared; line stores keep their contents and need no clearing.
`timescale 1ns / 1ps

module box_filter_3x3_rgb_unit #(
    parameter int MAX_LINE    = 1024,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,  // red_in, green_in, blue_in
    input  logic                                      s_tuser,  // frame_start
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,  // red_mean, green_mean, blue_mean
    output logic                                      m_tlast,  // frame_done
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [bf3_pkg::APB_ADDR_BITS-1:0]         paddr,
    input  logic [bf3_pkg::APB_DATA_BITS-1:0]         pwdata,
    output logic [bf3_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                      pready
);
    import bf3_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_LINE);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int PIX_W   = 3 * SAMPLE_BITS;
    localparam int TDATA_W = ((PIX_W + 7) / 8) * 8;

    logic [CNT_W-1:0]    eff_width;
    logic [ROW_BITS-1:0] eff_height;
    logic [ADDR_W-1:0]   col_addr;
    item_tag_t           tag, s1_tag_reg;
    logic [PIX_W-1:0]    col_upper, col_middle, col_lower, mean;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next, s2_last_reg;
    logic m_valid_reg, m_valid_next, m_last_reg;
    logic out_go, s2_free, s1_move, s2_load, s2_move, accept;

    assign out_go   = !m_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_go;
    assign s1_move  = s1_valid_reg && (!s1_tag_reg.emit || s2_free);
    assign s2_load  = s1_move && s1_tag_reg.emit;
    assign s2_move  = s2_valid_reg && out_go;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
        m_valid_next  = s2_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tag_reg <= tag;
        end
        if (s2_load) begin
            s2_last_reg <= s1_tag_reg.last;
        end
        if (s2_move) begin
            m_last_reg <= s2_last_reg;
        end
    end

    bf3_cfg_regs #(
        .MAX_LINE (MAX_LINE)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .eff_width  (eff_width),
        .eff_height (eff_height)
    );

    bf3_pos_track #(
        .MAX_LINE (MAX_LINE)
    ) u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .frame_start (s_tuser),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .col_addr    (col_addr),
        .tag         (tag)
    );

    bf3_line_buf #(
        .MAX_LINE    (MAX_LINE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_addr    (col_addr),
        .pix_in     (s_tdata[PIX_W-1:0]),
        .wr_en      (s1_move),
        .col_upper  (col_upper),
        .col_middle (col_middle),
        .col_lower  (col_lower)
    );

    bf3_window_mean #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .col_upper  (col_upper),
        .col_middle (col_middle),
        .col_lower  (col_lower),
        .shift_en   (s1_move),
        .sum_en     (s2_load),
        .out_en     (s2_move),
        .mean       (mean)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = TDATA_W'(mean);

endmodule

/* design/bf3_checker.sv */
// Port-level checker for the box filter, bound to the top level.
// Depends on assert_macros.svh and box_filter_3x3_rgb_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bf3_checker #(
    parameter int TDATA_W = 24
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    `BF3_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `BF3_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    `BF3_ASSERT_IMP(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready, s_tready)
    `BF3_ASSERT_IMP(a_no_early_out, aclk, aresetn, $past(!aresetn, 1) || $past(!aresetn, 2) || ($past(!aresetn, 3) && !$past(in_xfer, 3)), !m_tvalid)

endmodule

bind box_filter_3x3_rgb_unit bf3_checker #(
    .TDATA_W (TDATA_W)
) u_bf3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
